// ----- sv/cfd_pkg.sv -----
`default_nettype none

package cfd_pkg;

    localparam logic [7:0] FULL_CODE   = 8'hFF;
    localparam int         QUEUE_DEPTH = 4;
    localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int         QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_CODE = 2'd1,
        ST_TRUNCATED = 2'd2,
        ST_CAPACITY  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        done;
        status_t     status;
        logic [15:0] length;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/cfd_front.sv -----
`default_nettype none

module cfd_front #(
    parameter int LEN_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [15:0]      cfg_wdata,
    input  wire logic             in_take,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_last,
    output cfd_pkg::result_t      res,
    output logic                  res_push
);

    localparam int CMP_W = (LEN_BITS > 16) ? LEN_BITS : 16;

    logic [15:0]         cap_reg;
    logic [7:0]          bytes_left_reg,   bytes_left_next;
    logic                zero_pending_reg, zero_pending_next;
    logic [LEN_BITS-1:0] count_reg,        count_next;
    cfd_pkg::status_t    err_reg,          err_next;

    logic                full;
    logic                emit_ok;
    logic [7:0]          emit_byte;
    logic [CMP_W-1:0]    count_wide;
    logic [LEN_BITS-1:0] count_after;
    logic [CMP_W-1:0]    length_wide;

    assign count_wide  = CMP_W'(count_reg);
    assign full        = count_wide >= CMP_W'(cap_reg);
    assign length_wide = CMP_W'(count_after);

    always_comb
    begin
        bytes_left_next   = bytes_left_reg;
        zero_pending_next = zero_pending_reg;
        count_after       = count_reg;
        err_next          = err_reg;
        emit_ok           = 1'b0;
        emit_byte         = 8'd0;

        if (err_reg == cfd_pkg::ST_OK)
        begin
            if (bytes_left_reg == 8'd0)
            begin
                // A code byte first settles the zero owed by the previous block.
                zero_pending_next = 1'b0;
                if (zero_pending_reg)
                begin
                    if (full)
                    begin
                        err_next = cfd_pkg::ST_CAPACITY;
                    end
                    else
                    begin
                        emit_ok     = 1'b1;
                        count_after = count_reg + LEN_BITS'(1);
                    end
                end
                if (err_next == cfd_pkg::ST_OK)
                begin
                    if (in_byte == 8'd0)
                    begin
                        err_next = cfd_pkg::ST_ZERO_CODE;
                    end
                    else
                    begin
                        bytes_left_next   = in_byte - 8'd1;
                        zero_pending_next = (in_byte != cfd_pkg::FULL_CODE);
                    end
                end
            end
            else
            begin
                bytes_left_next = bytes_left_reg - 8'd1;
                if (full)
                begin
                    err_next = cfd_pkg::ST_CAPACITY;
                end
                else
                begin
                    emit_ok     = 1'b1;
                    emit_byte   = in_byte;
                    count_after = count_reg + LEN_BITS'(1);
                end
            end
            if (in_last && err_next == cfd_pkg::ST_OK && bytes_left_next != 8'd0)
            begin
                err_next = cfd_pkg::ST_TRUNCATED;
            end
        end

        res.data_byte  = emit_byte;
        res.data_valid = emit_ok;
        res.done       = in_last;
        res.status     = in_last ? err_next : cfd_pkg::ST_OK;
        res.length     = in_last ? length_wide[15:0] : 16'd0;
        res_push       = in_take && (emit_ok || in_last);

        count_next = count_after;
        if (in_last)
        begin
            bytes_left_next   = 8'd0;
            zero_pending_next = 1'b0;
            count_next        = '0;
            err_next          = cfd_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg          <= 16'hFFFF;
            bytes_left_reg   <= 8'd0;
            zero_pending_reg <= 1'b0;
            count_reg        <= '0;
            err_reg          <= cfd_pkg::ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (in_take)
            begin
                bytes_left_reg   <= bytes_left_next;
                zero_pending_reg <= zero_pending_next;
                count_reg        <= count_next;
                err_reg          <= err_next;
            end
        end
    end

    // A frame end always leaves the decoder waiting for a fresh code byte.
    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && in_last) |=> (count_reg == '0 && err_reg == cfd_pkg::ST_OK
                                  && bytes_left_reg == 8'd0 && !zero_pending_reg))
        else $error("decoder state not cleared after frame end");

    // The emitted count never passes the capacity that was in force.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && res.data_valid && !cfg_we) |=>
            (CMP_W'(count_reg) <= CMP_W'(cap_reg) || $past(in_last)))
        else $error("byte emitted beyond capacity");

endmodule

`default_nettype wire

// ----- sv/cfd_back.sv -----
`default_nettype none

module cfd_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfd_pkg::result_t res,
    input  wire logic             res_push,
    output logic                  has_room,
    output cfd_pkg::result_t      head,
    output logic                  head_valid,
    input  wire logic             head_pop
);

    cfd_pkg::result_t                 mem [cfd_pkg::QUEUE_DEPTH];
    logic [cfd_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [cfd_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [cfd_pkg::QCNT_W-1:0]       count_reg,  count_next;
    logic                             do_pop;

    assign has_room   = count_reg != cfd_pkg::QCNT_W'(cfd_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];
    assign do_pop     = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = res_push ? wr_ptr_reg + cfd_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop   ? rd_ptr_reg + cfd_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (res_push && !do_pop)
        begin
            count_next = count_reg + cfd_pkg::QCNT_W'(1);
        end
        else if (do_pop && !res_push)
        begin
            count_next = count_reg - cfd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            mem[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> has_room)
        else $error("result pushed into a full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cfd_pkg::QCNT_W'(cfd_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    // Pointer distance must agree with the occupancy count.
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != cfd_pkg::QCNT_W'(cfd_pkg::QUEUE_DEPTH)) |->
            (cfd_pkg::QPTR_W'(wr_ptr_reg - rd_ptr_reg) == cfd_pkg::QPTR_W'(count_reg)))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- sv/cobs_frame_decoder_unit.sv -----
`default_nettype none

// Channel   Dir  Payload
// s_*       in   tdata[7:0] encoded byte, tlast final byte of the frame
// m_*       out  tdata decoded byte / status / length, tuser byte present, tlast frame done
// cfg_*     in   capacity write, 16-bit decoded length bound
//
// One encoded byte is accepted per cycle while the queue has room; the decoder state updates in that same cycle.
// A result is written into a four-entry queue and offered on the master side from its head.
// s_tready drops only when that queue is full, so a stalled consumer backs up after
// four pending results. Reset clears the frame state and sets the capacity to 65535.

module cobs_frame_decoder_unit #(
    parameter int LEN_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] out_byte, [9:8] status, [25:10] decoded_length
    output logic [0:0]       m_tuser,   // [0] out_valid
    output logic             m_tlast    // frame_done
);

    cfd_pkg::result_t res;
    cfd_pkg::result_t head;
    logic             res_push;
    logic             has_room;
    logic             in_take;

    assign s_tready = has_room;
    assign in_take  = s_tvalid && has_room;

    cfd_front #(
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_take   (in_take),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res       (res),
        .res_push  (res_push)
    );

    cfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .res_push   (res_push),
        .has_room   (has_room),
        .head       (head),
        .head_valid (m_tvalid),
        .head_pop   (m_tready)
    );

    assign m_tdata = {6'd0, head.length, head.status, head.data_byte};
    assign m_tuser = head.data_valid;
    assign m_tlast = head.done;

endmodule

`default_nettype wire

// ----- bench/tb_cobs_frame_decoder_unit.sv -----
`default_nettype none

module tb_cobs_frame_decoder_unit;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BYTES   = 210;
    localparam int MAX_PRINTED   = 40;

    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } enc_item_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;   // [7:0] in_byte
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;            // [7:0] out_byte, [9:8] status, [25:10] decoded_length
    logic [0:0]  m_tuser;            // [0] out_valid
    logic        m_tlast;

    cobs_frame_decoder_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Pending encoded bytes and the decoded results they are predicted to cause.
    enc_item_t         byte_q[$];
    cfd_pkg::result_t  decoded_q[$];
    logic [7:0]        plain_buf[$];
    logic [7:0]        frame_buf[$];

    // Decoder state as the bench sees it.
    logic [15:0]       cap_limit  = 16'hFFFF;
    logic [7:0]        blk_left   = 8'd0;
    logic              zero_owed  = 1'b0;
    logic [15:0]       out_count  = 16'd0;
    cfd_pkg::status_t  frame_err  = cfd_pkg::ST_OK;

    logic in_fired = 1'b0;
    logic quiet    = 1'b0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    int   hold_asked = 0;
    int   hold_served = 0;

    int mismatches = 0;
    int frames_seen = 0;
    int bytes_sent = 0;
    int data_bytes_seen = 0;
    int backpressure_cycles = 0;
    int cap_writes = 0;
    int status_count[4] = '{0, 0, 0, 0};

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Takes one output slot if the capacity allows it; otherwise flags the overflow.
    function automatic logic claim_out_slot();
        if (out_count >= cap_limit)
        begin
            if (frame_err == cfd_pkg::ST_OK)
                frame_err = cfd_pkg::ST_CAPACITY;
            return 1'b0;
        end
        out_count = out_count + 16'd1;
        return 1'b1;
    endfunction

    function automatic void decode_step(input logic [7:0] b, input logic fin,
                                        output logic produced, output cfd_pkg::result_t r);
        logic [7:0] ob;
        logic       emitted;
        ob = 8'h00;
        emitted = 1'b0;
        if (frame_err == cfd_pkg::ST_OK)
        begin
            if (blk_left == 8'd0)
            begin
                // A code byte first pays out the zero owed by the previous short block.
                if (zero_owed)
                begin
                    zero_owed = 1'b0;
                    emitted = claim_out_slot();
                end
                if (frame_err == cfd_pkg::ST_OK)
                begin
                    if (b == 8'h00)
                        frame_err = cfd_pkg::ST_ZERO_CODE;
                    else
                    begin
                        blk_left = b - 8'd1;
                        zero_owed = (b != cfd_pkg::FULL_CODE);
                    end
                end
            end
            else
            begin
                blk_left = blk_left - 8'd1;
                emitted = claim_out_slot();
                if (emitted)
                    ob = b;
            end
            if (fin && frame_err == cfd_pkg::ST_OK && blk_left != 8'd0)
                frame_err = cfd_pkg::ST_TRUNCATED;
        end
        produced = emitted || fin;
        r.data_byte  = emitted ? ob : 8'h00;
        r.data_valid = emitted;
        r.done       = fin;
        r.status     = fin ? frame_err : cfd_pkg::ST_OK;
        r.length     = fin ? out_count : 16'd0;
        if (fin)
        begin
            blk_left = 8'd0;
            zero_owed = 1'b0;
            out_count = 16'd0;
            frame_err = cfd_pkg::ST_OK;
        end
    endfunction

    // Monitor: predicts on every accepted request and checks every accepted result.
    always @(posedge clk)
    begin
        cfd_pkg::result_t seen;
        cfd_pkg::result_t want;
        cfd_pkg::result_t pred;
        logic             has;
        in_fired = rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && !s_tready)
            backpressure_cycles++;
        if (in_fired)
        begin
            decode_step(s_tdata, s_tlast, has, pred);
            if (has)
                decoded_q.push_back(pred);
            if (s_tlast)
            begin
                frames_seen++;
                status_count[pred.status]++;
            end
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.data_byte  = m_tdata[7:0];
            seen.status     = cfd_pkg::status_t'(m_tdata[9:8]);
            seen.length     = m_tdata[25:10];
            seen.data_valid = m_tuser[0];
            seen.done       = m_tlast;
            if (decoded_q.size() == 0)
                report_mismatch("result with nothing pending", m_tdata, 0);
            else
            begin
                want = decoded_q.pop_front();
                if (seen.data_valid)
                    data_bytes_seen++;
                if (seen.data_byte != want.data_byte)
                    report_mismatch("out_byte", seen.data_byte, want.data_byte);
                if (seen.data_valid != want.data_valid)
                    report_mismatch("out_valid", seen.data_valid, want.data_valid);
                if (seen.done != want.done)
                    report_mismatch("frame_done", seen.done, want.done);
                if (seen.status != want.status)
                    report_mismatch("status", seen.status, want.status);
                if (seen.length != want.length)
                    report_mismatch("decoded_length", seen.length, want.length);
            end
        end
    end

    // Sender: offers queued bytes, with random gaps until the final phase.
    always @(negedge clk)
    begin
        enc_item_t item;
        if (rst_n && (!s_tvalid || in_fired))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (byte_q.size() == 0)
                s_tvalid <= 1'b0;
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                send_gap = $urandom_range(0, 17);
                s_tvalid <= 1'b0;
            end
            else
            begin
                item = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= item.value;
                s_tlast  <= item.is_last;
                bytes_sent++;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                if (hold_left == 0)
                    hold_served++;
                m_tready <= 1'b0;
            end
            else if (hold_served < hold_asked)
            begin
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 17);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [7:0] v, input logic fin);
        enc_item_t item;
        item.value = v;
        item.is_last = fin;
        byte_q.push_back(item);
    endtask

    function automatic void encode_plain();
        int code_at;
        int run;
        frame_buf.delete();
        code_at = 0;
        run = 0;
        frame_buf.push_back(8'h01);
        foreach (plain_buf[i])
        begin
            if (plain_buf[i] == 8'h00)
            begin
                frame_buf[code_at] = 8'(run + 1);
                code_at = frame_buf.size();
                frame_buf.push_back(8'h01);
                run = 0;
            end
            else
            begin
                frame_buf.push_back(plain_buf[i]);
                run++;
                // A full block of 254 bytes carries no implied zero.
                if (run == 254)
                begin
                    frame_buf[code_at] = cfd_pkg::FULL_CODE;
                    code_at = frame_buf.size();
                    frame_buf.push_back(8'h01);
                    run = 0;
                end
            end
        end
        frame_buf[code_at] = 8'(run + 1);
    endfunction

    // Builds one frame, mostly well formed, sometimes damaged or pure noise.
    task automatic queue_random_frame(input int room, output int n);
        int len;
        int zpct;
        int pick;
        int idx;
        if (room > 350 && $urandom_range(0, 39) == 0)
            len = $urandom_range(260, 400);
        else if ($urandom_range(0, 5) == 0)
            len = $urandom_range(17, 80);
        else
            len = $urandom_range(0, 16);
        case ($urandom_range(0, 3))
            0: zpct = 0;
            1: zpct = 10;
            2: zpct = 40;
            default: zpct = 90;
        endcase
        plain_buf.delete();
        repeat (len)
            plain_buf.push_back(($urandom_range(0, 99) < zpct) ? 8'h00
                                                                : 8'($urandom_range(1, 255)));
        encode_plain();
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            idx = $urandom_range(0, frame_buf.size() - 1);
            frame_buf[idx] = 8'h00;
        end
        else if (pick == 1 && frame_buf.size() > 1)
        begin
            len = $urandom_range(1, frame_buf.size() - 1);
            while (frame_buf.size() > len)
                void'(frame_buf.pop_back());
        end
        else if (pick == 2)
        begin
            frame_buf.delete();
            repeat ($urandom_range(1, 12))
                frame_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 6))
                                                         : 8'($urandom_range(0, 255)));
        end
        foreach (frame_buf[i])
            push_byte(frame_buf[i], i == frame_buf.size() - 1);
        n = frame_buf.size();
    endtask

    // Returns once no request is queued or offered and every result has come back.
    task automatic wait_drained();
        @(posedge clk);
        while (byte_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cap_limit = v;
        cap_writes++;
    endtask

    initial
    begin
        logic [15:0] caps[8];
        int sent;
        int n;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames at the reset capacity.
        push_byte(8'h01, 1'b1);                            // empty frame
        push_byte(8'h00, 1'b1);                            // lone zero code
        push_byte(8'h03, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h80, 1'b1);
        push_byte(8'h02, 1'b0); push_byte(8'h11, 1'b0); push_byte(8'h01, 1'b1);
        push_byte(8'h05, 1'b0); push_byte(8'hAA, 1'b1);    // frame ends inside a block
        push_byte(8'h02, 1'b0); push_byte(8'h55, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h33, 1'b0); push_byte(8'h44, 1'b1);    // zero code, rest swallowed
        // A full block, which owes no zero before the next code byte.
        push_byte(cfd_pkg::FULL_CODE, 1'b0);
        repeat (254)
            push_byte(8'($urandom_range(1, 255)), 1'b0);
        push_byte(8'h02, 1'b0); push_byte(8'h11, 1'b1);
        wait_drained();

        // With room for one byte: data overflow, owed-zero overflow, owed zero that fits.
        write_capacity(16'd1);
        push_byte(8'h03, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b1);
        push_byte(8'h02, 1'b0); push_byte(8'h07, 1'b0); push_byte(8'h02, 1'b0);
        push_byte(8'h08, 1'b1);
        push_byte(8'h01, 1'b0); push_byte(8'h01, 1'b1);
        wait_drained();

        caps[0] = 16'hFFFF;
        caps[1] = 16'd0;
        caps[2] = 16'd3;
        caps[3] = 16'($urandom_range(4, 40));
        caps[4] = 16'hFFFF;
        caps[5] = 16'($urandom_range(0, 65535));
        caps[6] = 16'($urandom_range(0, 12));
        caps[7] = 16'hFFFF;
        for (int p = 0; p < 8; p++)
        begin
            write_capacity(caps[p]);
            if (p == 4)
                hold_asked++;
            if (p == 7)
                quiet = 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                queue_random_frame(PHASE_BYTES - sent, n);
                sent += n;
            end
            wait_drained();
        end

        if (decoded_q.size() != 0)
            report_mismatch("results still pending", decoded_q.size(), 0);
        $display("Covered %0d frames from %0d encoded bytes over %0d capacity writes; %s",
                 frames_seen, bytes_sent, cap_writes, "status counts below.");
        $display("Status ok/zero/truncated/capacity = %0d/%0d/%0d/%0d; decoded %0d bytes; %s",
                 status_count[0], status_count[1], status_count[2], status_count[3],
                 data_bytes_seen, "input stall and hold-off counts follow.");
        $display("Input stalled on %0d cycles; %0d long hold-offs.",
                 backpressure_cycles, hold_served);
        if (mismatches == 0)
            $display("tb_cobs_frame_decoder_unit OK");
        else
            $display("tb_cobs_frame_decoder_unit NOT OK");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("tb_cobs_frame_decoder_unit NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/cfd_pkg.sv
sv/cfd_front.sv
sv/cfd_back.sv
sv/cobs_frame_decoder_unit.sv
bench/tb_cobs_frame_decoder_unit.sv
